[rtl/core/fra_pkg.sv]
// Shared types and operation codes for the fraction arithmetic block.
package fra_pkg;

   localparam int ResultWidth = 32;
   localparam int TermWidth   = 16;

   localparam logic [1:0] KIND_ADD  = 2'd0;
   localparam logic [1:0] KIND_MUL  = 2'd1;
   localparam logic [1:0] KIND_DIV  = 2'd2;
   localparam logic [1:0] KIND_NONE = 2'd3;

   typedef struct packed {
      logic [1:0]                  kind;
      logic signed [TermWidth-1:0] first_num;
      logic signed [TermWidth-1:0] first_den;
      logic signed [TermWidth-1:0] second_num;
      logic signed [TermWidth-1:0] second_den;
   } req_type;

   typedef struct packed {
      logic signed [ResultWidth-1:0] result_num;
      logic signed [ResultWidth-1:0] result_den;
   } rsp_type;

   // Work handed from front to back: raw result terms.
   typedef struct packed {
      logic [ResultWidth-1:0] num;
      logic [ResultWidth-1:0] den;
   } pair_type;

endpackage

[rtl/core/fraction_arith_reduce.sv]
// Top level of the fraction arithmetic and reduction block.
//
// The req_ channel takes one word: an operation kind (add, multiply,
// divide, none) and two signed fractions. The rsp_ channel returns one
// word per request: numerator and denominator, reduced by their gcd when
// both are strictly positive, otherwise passed on as formed.
// The front forms the products on one shared multiplier.
// The back runs a binary gcd on the 32-bit terms and two restoring
// divisions, numerator first; unreduced words skip both and go straight
// to the result register. The gcd and divide unit sets the rate.
// A two-word queue sits between front and back, so the front takes a new
// request while the back is busy and the back holds its result while
// rsp_stall is high; the result word does not change while stalled.
// Synchronous reset empties the queue and returns both parts to idle.
module fraction_arith_reduce import fra_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic     f_valid, f_stall, b_valid, b_stall;
   pair_type f_pair, b_pair;

   fra_front #(.TERM_WIDTH(TermWidth)) u_front (
      .clock, .reset, .req_valid, .req_stall,
      .in_kind(req_data.kind), .in_a(req_data.first_num), .in_b(req_data.first_den),
      .in_c(req_data.second_num), .in_d(req_data.second_den),
      .out_valid(f_valid), .out_stall(f_stall), .out_pair(f_pair)
   );

   fra_queue u_queue (
      .clock, .reset, .in_valid(f_valid), .in_stall(f_stall), .in_pair(f_pair),
      .out_valid(b_valid), .out_stall(b_stall), .out_pair(b_pair)
   );

   fra_back u_back (
      .clock, .reset, .in_valid(b_valid), .in_stall(b_stall), .in_pair(b_pair),
      .rsp_valid, .rsp_stall, .rsp_data
   );

endmodule

[rtl/core/fra_front.sv]
// Front end: accepts a word, forms the unreduced fraction with one multiplier.
module fra_front import fra_pkg::*; #(
   parameter int TERM_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            in_kind,
   input  logic [TERM_WIDTH-1:0] in_a,
   input  logic [TERM_WIDTH-1:0] in_b,
   input  logic [TERM_WIDTH-1:0] in_c,
   input  logic [TERM_WIDTH-1:0] in_d,
   output logic                  out_valid,
   input  logic                  out_stall,
   output pair_type              out_pair
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_P0   = 3'd1;
   localparam logic [2:0] ST_P1   = 3'd2;
   localparam logic [2:0] ST_P2   = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [1:0]             kind_ff;
   logic [TERM_WIDTH-1:0]  a_ff, b_ff, c_ff, d_ff;
   logic [ResultWidth-1:0] num_ff, num_in, den_ff, den_in;
   logic [TERM_WIDTH-1:0]  mx, my;
   logic [ResultWidth-1:0] sx, sy, prod;
   logic signed [2*ResultWidth-1:0] wide;

   assign req_stall = (state_ff != ST_IDLE);
   assign out_valid = (state_ff == ST_DONE);
   assign out_pair  = '{num: num_ff, den: den_ff};

   always_comb begin
      mx = a_ff; my = d_ff;
      case (state_ff)
         ST_P0: begin mx = a_ff; my = (kind_ff == KIND_MUL) ? c_ff : d_ff; end
         ST_P1: begin mx = c_ff; my = b_ff; end
         ST_P2: begin mx = b_ff; my = (kind_ff == KIND_DIV) ? c_ff : d_ff; end
         default: begin mx = a_ff; my = d_ff; end
      endcase
      sx = ResultWidth'($signed(mx));
      sy = ResultWidth'($signed(my));
      wide = $signed(sx) * $signed(sy);
      prod = wide[ResultWidth-1:0];
   end

   always_comb begin
      state_in = state_ff;
      num_in = num_ff;
      den_in = den_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) begin
            state_in = (in_kind == KIND_NONE) ? ST_DONE : ST_P0;
            num_in = ResultWidth'($signed(in_a));
            den_in = ResultWidth'($signed(in_b));
         end
         ST_P0: begin
            num_in = prod;
            state_in = (kind_ff == KIND_ADD) ? ST_P1 : ST_P2;
         end
         ST_P1: begin
            num_in = num_ff + prod;
            state_in = ST_P2;
         end
         ST_P2: begin
            den_in = prod;
            state_in = ST_DONE;
         end
         ST_DONE: if (!out_stall) begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      if (state_ff == ST_IDLE && req_valid) begin
         kind_ff <= in_kind;
         a_ff <= in_a; b_ff <= in_b; c_ff <= in_c; d_ff <= in_d;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_P1) |-> $past(kind_ff == KIND_ADD))
      else $error("sum step outside add");
   assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_stall) |=> (out_valid && $stable(out_pair)))
      else $error("front pair changed while held");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_P2) |=> (state_ff == ST_DONE))
      else $error("front sequence broken");

endmodule

[rtl/core/fra_queue.sv]
// Two-entry queue between front and back.
module fra_queue import fra_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_stall,
   input  pair_type in_pair,
   output logic     out_valid,
   input  logic     out_stall,
   output pair_type out_pair
);

   pair_type   mem_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_stall  = (cnt_ff == 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_pair  = mem_ff[rd_ff];
   assign push = in_valid && !in_stall;
   assign pop  = out_valid && !out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0; rd_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop) rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
      if (push) mem_ff[wr_ff] <= in_pair;
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue overflow");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0) |-> (wr_ff == rd_ff))
      else $error("queue pointers disagree when empty");

endmodule

[rtl/core/fra_back.sv]
// Back end: binary GCD and restoring divisions, then the result register.
module fra_back import fra_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_stall,
   input  pair_type in_pair,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   localparam int CountWidth = $clog2(ResultWidth + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_GCD  = 3'd1;
   localparam logic [2:0] ST_DIVN = 3'd2;
   localparam logic [2:0] ST_DIVD = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [ResultWidth-1:0] num_ff, den_ff, u_ff, v_ff, g_ff;
   logic [ResultWidth-1:0] q_ff, r_ff, dividend_ff;
   logic [CountWidth-1:0]  shift_ff, bit_ff;
   logic [ResultWidth:0]   trial;
   logic [ResultWidth-1:0] rem_sh;
   logic                   pos_n, pos_d;

   assign pos_n = (in_pair.num != '0) && !in_pair.num[ResultWidth-1];
   assign pos_d = (in_pair.den != '0) && !in_pair.den[ResultWidth-1];
   assign in_stall  = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data  = '{result_num: num_ff, result_den: den_ff};

   assign rem_sh = {r_ff[ResultWidth-2:0], dividend_ff[ResultWidth-1]};
   assign trial  = {1'b0, rem_sh} - {1'b0, g_ff};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (in_valid) state_in = (pos_n && pos_d) ? ST_GCD : ST_OUT;
         ST_GCD: if (v_ff == '0 || u_ff == v_ff) state_in = ST_DIVN;
         ST_DIVN: if (bit_ff == '0) state_in = ST_DIVD;
         ST_DIVD: if (bit_ff == '0) state_in = ST_OUT;
         ST_OUT: if (!rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      case (state_ff)
         ST_IDLE: if (in_valid) begin
            num_ff <= in_pair.num;
            den_ff <= in_pair.den;
            u_ff <= in_pair.num;
            v_ff <= in_pair.den;
            shift_ff <= '0;
         end
         ST_GCD: begin
            if (v_ff == '0 || u_ff == v_ff) begin
               g_ff <= u_ff << shift_ff;
               dividend_ff <= num_ff;
               r_ff <= '0;
               q_ff <= '0;
               bit_ff <= CountWidth'(ResultWidth - 1);
            end else if (!u_ff[0] && !v_ff[0]) begin
               u_ff <= u_ff >> 1; v_ff <= v_ff >> 1;
               shift_ff <= shift_ff + CountWidth'(1);
            end else if (!u_ff[0]) begin
               u_ff <= u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_ff <= v_ff >> 1;
            end else if (u_ff > v_ff) begin
               u_ff <= (u_ff - v_ff) >> 1;
            end else begin
               v_ff <= (v_ff - u_ff) >> 1;
            end
         end
         ST_DIVN, ST_DIVD: begin
            dividend_ff <= dividend_ff << 1;
            if (!trial[ResultWidth]) begin
               r_ff <= trial[ResultWidth-1:0];
               q_ff <= {q_ff[ResultWidth-2:0], 1'b1};
            end else begin
               r_ff <= rem_sh;
               q_ff <= {q_ff[ResultWidth-2:0], 1'b0};
            end
            if (bit_ff == '0) begin
               if (state_ff == ST_DIVN) begin
                  num_ff <= {q_ff[ResultWidth-2:0], !trial[ResultWidth]};
                  dividend_ff <= den_ff;
                  r_ff <= '0;
                  bit_ff <= CountWidth'(ResultWidth - 1);
               end else begin
                  den_ff <= {q_ff[ResultWidth-2:0], !trial[ResultWidth]};
               end
            end else begin
               bit_ff <= bit_ff - CountWidth'(1);
            end
         end
         default: ;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVN) |-> (g_ff != '0))
      else $error("division by zero divisor");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result changed while held");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GCD) |-> (u_ff != '0))
      else $error("gcd operand vanished");

endmodule
